// ----- rtl/sdr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdr_pkg
// Shared types and constants of the strided dimension reduction engine.
// ----------------------------------------------------------------------------
package sdr_pkg;

  // fixed field widths of the ports
  localparam int VALUE_W = 32;
  localparam int ACC_W   = 48;
  localparam int BIDX_W  = 12;
  localparam int POS_W   = 10;
  localparam int CFG_IW  = 2;
  localparam int CFG_DW  = 13;

  // raw register field widths
  localparam int RLEN_W  = 13;
  localparam int ILEN_W  = 11;

  // output buffer
  localparam int OBUF_DEPTH = 4;
  localparam int OBUF_AW    = 2;
  localparam int OBUF_CW    = 3;

  // saturation limits of the running sum
  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // reduction modes
  typedef enum logic {
    MODE_SUM = 1'b0,
    MODE_MAX = 1'b1
  } mode_t;

  // configuration register indexes
  typedef enum logic [CFG_IW-1:0] {
    CFG_MODE       = 2'd0,
    CFG_REDUCE_LEN = 2'd1,
    CFG_INNER_LEN  = 2'd2,
    CFG_UNUSED     = 2'd3
  } cfg_idx_t;

  // one result word
  typedef struct packed {
    logic [ACC_W-1:0]  result;
    logic [BIDX_W-1:0] best_index;
    logic [POS_W-1:0]  position;
    logic              group_end;
  } res_t;

endpackage

`default_nettype wire

// ----- rtl/sdr_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdr_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// A read at the address being written returns the old contents.
// ----------------------------------------------------------------------------
module sdr_ram #(
  parameter int WIDTH = 60,
  parameter int DEPTH = 1024
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic                                      re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/sdr_obuf.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdr_obuf
// Small result buffer between the accumulator pipeline and the output
// channel, so the pipeline keeps moving while a result waits.
// ----------------------------------------------------------------------------
module sdr_obuf (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire sdr_pkg::res_t         push_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output sdr_pkg::res_t              out_data,
  output logic [sdr_pkg::OBUF_CW-1:0] count
);
  import sdr_pkg::*;

  res_t               buf_r [OBUF_DEPTH];
  logic [OBUF_AW-1:0] wptr_r;
  logic [OBUF_AW-1:0] rptr_r;
  logic [OBUF_CW-1:0] cnt_r;
  logic               pop;

  assign out_valid = (cnt_r != '0);
  assign out_data  = buf_r[rptr_r];
  assign pop       = out_valid && !out_stall;
  assign count     = cnt_r;

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wptr_r] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/strided_dim_reduction_engine.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// strided_dim_reduction_engine
// Reduces a streamed row-major tensor along one axis (sum or max/argmax).
// ----------------------------------------------------------------------------
// One element is taken every clock cycle while in_stall is low. Each element
// does one read-modify-write of its inner position's accumulator, held
// together with its best index in a single RAM with a registered read; the
// element that follows at the same position gets the fresh value through a
// forwarding register. The result of a last-row element passes through the
// stage 1 registers and a four-word buffer to the out_ channel, so input is
// only held off when that buffer has backed up under out_stall.
// No clearing pass is needed after reset: the first row of each group loads
// every accumulator it later reads. A write to any register but the unused
// index restarts the group and row counters.
module strided_dim_reduction_engine #(
  parameter int INNER_MAX  = 1024,
  parameter int REDUCE_MAX = 4096,
  parameter int VALUE_BITS = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // configuration
  input  wire logic                         cfg_we,
  input  wire logic [sdr_pkg::CFG_IW-1:0]   cfg_index,
  input  wire logic [sdr_pkg::CFG_DW-1:0]   cfg_data,
  // input words
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [sdr_pkg::VALUE_W-1:0]  in_value,
  // result words
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [sdr_pkg::ACC_W-1:0]         out_result,
  output logic [sdr_pkg::BIDX_W-1:0]        out_best_index,
  output logic [sdr_pkg::POS_W-1:0]         out_position,
  output logic                              out_group_end
);
  import sdr_pkg::*;

  localparam int IAW    = (INNER_MAX > 1) ? $clog2(INNER_MAX) : 1;
  localparam int RCW    = (REDUCE_MAX > 1) ? $clog2(REDUCE_MAX) : 1;
  localparam int WORD_W = ACC_W + BIDX_W;

  // configuration state
  mode_t          mode_r;
  logic [RCW-1:0] rlast_r;
  logic [IAW-1:0] ilast_r;

  // stream position
  logic [RCW-1:0] rcnt_r, rcnt_nxt;
  logic [IAW-1:0] icnt_r, icnt_nxt;

  // stage 1
  logic                    s1_v_r;
  logic [IAW-1:0]          s1_addr_r;
  logic                    s1_first_r;
  logic                    s1_last_r;
  logic                    s1_gend_r;
  logic [RCW-1:0]          s1_ridx_r;
  logic signed [ACC_W-1:0] s1_val_r;
  mode_t                   s1_mode_r;

  // forwarding of the most recent write
  logic              fwd_v_r;
  logic [IAW-1:0]    fwd_addr_r;
  logic [WORD_W-1:0] fwd_data_r;

  logic                         accept;
  logic [ACC_W-1:0]             wide_value;
  logic signed [VALUE_BITS-1:0] trunc_value;
  logic signed [ACC_W-1:0]      ext_value;
  logic [31:0]                  rlen_clamp;
  logic [31:0]                  ilen_clamp;

  logic [WORD_W-1:0]       ram_rdata;
  logic [WORD_W-1:0]       old_word;
  logic signed [ACC_W-1:0] old_acc;
  logic [BIDX_W-1:0]       old_bidx;
  logic signed [ACC_W:0]   sum_wide;
  logic signed [ACC_W-1:0] sum_sat;
  logic signed [ACC_W-1:0] new_acc;
  logic [BIDX_W-1:0]       new_bidx;
  logic                    push;
  res_t                    push_data;
  res_t                    out_data;
  logic [OBUF_CW-1:0]      obuf_cnt;

  // hold off input while the result buffer cannot take one more word
  assign in_stall = (obuf_cnt == OBUF_CW'(OBUF_DEPTH)) ||
                    ((obuf_cnt == OBUF_CW'(OBUF_DEPTH - 1)) && push);
  assign accept   = in_valid && !in_stall;

  // sign extension of the low VALUE_BITS bits
  assign wide_value  = ACC_W'(in_value);
  assign trunc_value = wide_value[VALUE_BITS-1:0];
  assign ext_value   = ACC_W'(trunc_value);

  // length clamping, zero acts as one
  always_comb begin
    rlen_clamp = 32'(cfg_data[RLEN_W-1:0]);
    if (rlen_clamp == 32'd0) begin
      rlen_clamp = 32'd1;
    end else if (rlen_clamp > 32'(REDUCE_MAX)) begin
      rlen_clamp = 32'(REDUCE_MAX);
    end
    ilen_clamp = 32'(cfg_data[ILEN_W-1:0]);
    if (ilen_clamp == 32'd0) begin
      ilen_clamp = 32'd1;
    end else if (ilen_clamp > 32'(INNER_MAX)) begin
      ilen_clamp = 32'(INNER_MAX);
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_SUM;
      rlast_r <= '0;
      ilast_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MODE:       mode_r  <= mode_t'(cfg_data[0]);
        CFG_REDUCE_LEN: rlast_r <= RCW'(rlen_clamp - 32'd1);
        CFG_INNER_LEN:  ilast_r <= IAW'(ilen_clamp - 32'd1);
        CFG_UNUSED:     ;
      endcase
    end
  end

  // next stream position
  always_comb begin
    rcnt_nxt = rcnt_r;
    icnt_nxt = icnt_r;
    if (cfg_we && (cfg_idx_t'(cfg_index) != CFG_UNUSED)) begin
      rcnt_nxt = '0;
      icnt_nxt = '0;
    end else if (accept) begin
      if (icnt_r == ilast_r) begin
        icnt_nxt = '0;
        rcnt_nxt = (rcnt_r == rlast_r) ? '0 : rcnt_r + 1'b1;
      end else begin
        icnt_nxt = icnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rcnt_r <= '0;
      icnt_r <= '0;
    end else begin
      rcnt_r <= rcnt_nxt;
      icnt_r <= icnt_nxt;
    end
  end

  // stage 1 capture, in step with the RAM read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= accept;
    end
    if (accept) begin
      s1_addr_r  <= icnt_r;
      s1_first_r <= (rcnt_r == '0);
      s1_last_r  <= (rcnt_r == rlast_r);
      s1_gend_r  <= (icnt_r == ilast_r);
      s1_ridx_r  <= rcnt_r;
      s1_val_r   <= ext_value;
      s1_mode_r  <= mode_r;
    end
  end

  // accumulator memory
  sdr_ram #(
    .WIDTH (WORD_W),
    .DEPTH (INNER_MAX)
  ) u_acc_ram (
    .clk   (clk),
    .we    (s1_v_r),
    .waddr (s1_addr_r),
    .wdata ({new_bidx, new_acc}),
    .re    (accept),
    .raddr (icnt_r),
    .rdata (ram_rdata)
  );

  // pick up a write that landed on the same edge as the read
  assign old_word = (fwd_v_r && (fwd_addr_r == s1_addr_r)) ? fwd_data_r : ram_rdata;
  assign old_acc  = old_word[ACC_W-1:0];
  assign old_bidx = old_word[WORD_W-1:ACC_W];

  // saturating sum
  assign sum_wide = {old_acc[ACC_W-1], old_acc} + {s1_val_r[ACC_W-1], s1_val_r};
  always_comb begin
    if (sum_wide[ACC_W] != sum_wide[ACC_W-1]) begin
      sum_sat = sum_wide[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      sum_sat = sum_wide[ACC_W-1:0];
    end
  end

  // accumulator update
  always_comb begin
    new_acc  = old_acc;
    new_bidx = old_bidx;
    priority if (s1_first_r) begin
      new_acc  = s1_val_r;
      new_bidx = '0;
    end else if (s1_mode_r == MODE_SUM) begin
      new_acc  = sum_sat;
      new_bidx = '0;
    end else if (s1_val_r > old_acc) begin
      new_acc  = s1_val_r;
      new_bidx = BIDX_W'(s1_ridx_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_v_r <= 1'b0;
    end else if (s1_v_r) begin
      fwd_v_r <= 1'b1;
    end
    if (s1_v_r) begin
      fwd_addr_r <= s1_addr_r;
      fwd_data_r <= {new_bidx, new_acc};
    end
  end

  // result word on the last row
  assign push                 = s1_v_r && s1_last_r;
  assign push_data.result     = new_acc;
  assign push_data.best_index = (s1_mode_r == MODE_MAX) ? new_bidx : '0;
  assign push_data.position   = POS_W'(s1_addr_r);
  assign push_data.group_end  = s1_gend_r;

  sdr_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .count     (obuf_cnt)
  );

  assign out_result     = out_data.result;
  assign out_best_index = out_data.best_index;
  assign out_position   = out_data.position;
  assign out_group_end  = out_data.group_end;

  // result buffer never overflows
  a_obuf_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (obuf_cnt != OBUF_CW'(OBUF_DEPTH)) || (out_valid && !out_stall))
    else $error("result buffer overflow");

  // stream position stays inside the configured shape
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (icnt_r <= ilast_r) && (rcnt_r <= rlast_r))
    else $error("stream counter out of range");

  // end of a row wraps the inner counter
  a_row_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (icnt_r == ilast_r)) |=> (icnt_r == '0))
    else $error("inner counter did not wrap");

  // group end only on the last inner position
  a_gend_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (push && s1_gend_r) |-> (s1_addr_r == ilast_r))
    else $error("group end on wrong position");

endmodule

`default_nettype wire

// ----- tb/sv/tb_strided_dim_reduction_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_strided_dim_reduction_engine
// Self-checking bench for the strided axis reduction engine. A directed table
// covers reset defaults, value extremes, ties, length clamping and register
// writes. Random groups follow, then short runs at the largest axis sizes.
// Each result word is compared with its table entry or with a predictor in the bench.
// ----------------------------------------------------------------------------
module tb_strided_dim_reduction_engine;
  import sdr_pkg::*;

  localparam int INNER_MAX   = 1024;
  localparam int REDUCE_MAX  = 4096;
  localparam int QUIET_LIMIT = 5000;
  localparam int DRAIN_WAIT  = 10;

  typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    cfg_idx_t          idx;
    logic [CFG_DW-1:0] data;
    logic [VALUE_W-1:0] value;
    bit                typed;
    res_t              res;
  } stim_row_t;

  // dut ports
  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CFG_IW-1:0]   cfg_index = CFG_MODE;
  logic [CFG_DW-1:0]   cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [VALUE_W-1:0]  in_value = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [ACC_W-1:0]    out_result;
  logic [BIDX_W-1:0]   out_best_index;
  logic [POS_W-1:0]    out_position;
  logic                out_group_end;

  // predictor state
  logic signed [ACC_W-1:0] acc_mem [INNER_MAX];
  logic [BIDX_W-1:0]       argmax_mem [INNER_MAX];
  int unsigned             row_count;
  int unsigned             col_count;
  mode_t                   cur_mode;
  logic [RLEN_W-1:0]       rlen_raw;
  logic [ILEN_W-1:0]       ilen_raw;

  // expected result words, oldest first
  res_t        due_reductions[$];
  stim_row_t   stim_rows[$];

  // bookkeeping
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned words_sent = 0;
  int unsigned random_words = 0;
  int unsigned sweep_words = 0;
  int unsigned reg_writes = 0;
  int unsigned burst_left = 0;
  int unsigned stall_left = 0;
  int unsigned stall_style = 0;
  int unsigned stall_tick = 0;
  int unsigned quiet_cycles = 0;
  logic [VALUE_W-1:0] prev_value = '0;

  always #4 clk = ~clk;

  strided_dim_reduction_engine #(
    .INNER_MAX  (INNER_MAX),
    .REDUCE_MAX (REDUCE_MAX),
    .VALUE_BITS (VALUE_W)
  ) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_result     (out_result),
    .out_best_index (out_best_index),
    .out_position   (out_position),
    .out_group_end  (out_group_end)
  );

  // zero and oversize lengths fold into the legal range
  function automatic int unsigned span(input int unsigned raw, input int unsigned hi);
    if (raw == 0) return 1;
    if (raw > hi) return hi;
    return raw;
  endfunction

  // append to the expected result queue
  function automatic void expect_word(input res_t w);
    due_reductions = {due_reductions, w};
  endfunction

  // append to the stimulus table
  function automatic void queue_row(input stim_row_t row);
    stim_rows = {stim_rows, row};
  endfunction

  // one element through the accumulators; returns 1 when a result word is due
  function automatic bit fold_element(input logic [VALUE_W-1:0] raw, output res_t r);
    int unsigned rl, il, pos;
    logic signed [ACC_W-1:0] v, a;
    logic [ACC_W:0] s;
    bit hit;
    rl = span(rlen_raw, REDUCE_MAX);
    il = span(ilen_raw, INNER_MAX);
    pos = col_count;
    v = $signed(raw);
    hit = 1'b0;
    r = '0;
    if (pos >= il) pos = 0;
    if (row_count >= rl) row_count = 0;
    a = acc_mem[pos];
    if (row_count == 0) begin
      acc_mem[pos] = v;
      argmax_mem[pos] = '0;
    end else if (cur_mode == MODE_SUM) begin
      s = {a[ACC_W-1], a} + {v[ACC_W-1], v};
      // saturate when the carry out disagrees with the sign
      if (s[ACC_W] != s[ACC_W-1]) acc_mem[pos] = s[ACC_W] ? ACC_MIN : ACC_MAX;
      else acc_mem[pos] = s[ACC_W-1:0];
      argmax_mem[pos] = '0;
    end else if (v > a) begin
      acc_mem[pos] = v;
      argmax_mem[pos] = BIDX_W'(row_count);
    end
    if (row_count == rl - 1) begin
      r.result     = acc_mem[pos];
      r.best_index = (cur_mode == MODE_MAX) ? argmax_mem[pos] : '0;
      r.position   = POS_W'(pos);
      r.group_end  = (pos == il - 1);
      hit = 1'b1;
    end
    pos++;
    if (pos >= il) begin
      pos = 0;
      row_count++;
      if (row_count >= rl) row_count = 0;
    end
    col_count = pos;
    return hit;
  endfunction

  // table helpers
  function automatic void add_word(input logic [VALUE_W-1:0] v);
    stim_row_t row;
    row = '{ROW_WORD, CFG_MODE, '0, v, 1'b0, '0};
    queue_row(row);
  endfunction

  function automatic void add_word_exp(input logic [VALUE_W-1:0] v, input logic [ACC_W-1:0] res,
                                       input logic [BIDX_W-1:0] bidx,
                                       input logic [POS_W-1:0] pos, input logic ge);
    stim_row_t row;
    row = '{ROW_WORD, CFG_MODE, '0, v, 1'b1, '0};
    row.res.result = res;
    row.res.best_index = bidx;
    row.res.position = pos;
    row.res.group_end = ge;
    queue_row(row);
  endfunction

  function automatic void add_reg(input cfg_idx_t idx, input logic [CFG_DW-1:0] d);
    stim_row_t row;
    row = '{ROW_REG, idx, d, '0, 1'b0, '0};
    queue_row(row);
  endfunction

  // mix of extremes, repeats for ties, small values and full-range noise
  function automatic logic [VALUE_W-1:0] pick_value();
    logic [VALUE_W-1:0] v;
    case ($urandom_range(0, 9))
      0: v = 32'h7FFF_FFFF;
      1: v = 32'h8000_0000;
      2: v = prev_value;
      3, 4: v = VALUE_W'(int'($urandom_range(0, 2000)) - 1000);
      default: v = $urandom;
    endcase
    prev_value = v;
    return v;
  endfunction

  function automatic logic [CFG_DW-1:0] pick_len(input int unsigned hi);
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return '0;
    if (sel < 8) return CFG_DW'($urandom_range(1, 6));
    return CFG_DW'($urandom_range(7, hi));
  endfunction

  // send one word in bursts with random gaps; called just after a rising edge
  task automatic push_word(input logic [VALUE_W-1:0] v, input bit typed, input res_t typed_res);
    int unsigned gap;
    res_t r;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 24);
      gap = $urandom_range(0, 5);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_value <= v;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    words_sent++;
    if (fold_element(v, r)) expect_word(typed ? typed_res : r);
    else if (typed) expect_word(typed_res);
  endtask

  // register write once the block has drained
  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DW-1:0] d);
    in_valid <= 1'b0;
    while (due_reductions.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    reg_writes++;
    burst_left = 0;
    case (idx)
      CFG_MODE:       cur_mode = mode_t'(d[0]);
      CFG_REDUCE_LEN: rlen_raw = d[RLEN_W-1:0];
      CFG_INNER_LEN:  ilen_raw = d[ILEN_W-1:0];
      default: ;
    endcase
    if (idx != CFG_UNUSED) begin
      row_count = 0;
      col_count = 0;
    end
  endtask

  // random shape, whole groups plus sometimes a cut-off tail
  task automatic run_random_phase();
    int unsigned rl, il, groups, n;
    logic [CFG_DW-1:0] d;
    if ($urandom_range(0, 3) != 0) write_reg(CFG_MODE, CFG_DW'($urandom));
    if ($urandom_range(0, 3) != 0) write_reg(CFG_REDUCE_LEN, pick_len(24));
    if ($urandom_range(0, 3) != 0) begin
      d = pick_len(24);
      if ($urandom_range(0, 1) != 0) d[CFG_DW-1:ILEN_W] = 2'($urandom);
      write_reg(CFG_INNER_LEN, d);
    end
    if ($urandom_range(0, 15) == 0) write_reg(CFG_UNUSED, CFG_DW'($urandom));
    rl = span(rlen_raw, REDUCE_MAX);
    il = span(ilen_raw, INNER_MAX);
    groups = $urandom_range(1, 3);
    while (groups > 1 && groups * rl * il > 240) groups--;
    n = groups * rl * il;
    if (rl * il > 1 && $urandom_range(0, 3) == 0) n += $urandom_range(1, rl * il - 1);
    // keep each phase short so the total stays near the planned count
    if (n > 120) n = 120;
    repeat (n) push_word(pick_value(), 1'b0, '0);
    random_words += n;
  endtask

  // short run at the size limits
  task automatic sweep(input mode_t m, input logic [CFG_DW-1:0] rl, input logic [CFG_DW-1:0] il,
                       input int unsigned n, input bit peak_last);
    write_reg(CFG_MODE, CFG_DW'(m));
    write_reg(CFG_REDUCE_LEN, rl);
    write_reg(CFG_INNER_LEN, il);
    repeat (n - 1) push_word($urandom, 1'b0, '0);
    push_word(peak_last ? 32'h7FFF_FFFF : $urandom, 1'b0, '0);
    sweep_words += n;
  endtask

  // result checker and receiver stall pattern
  always @(posedge clk) begin
    res_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_result, out_best_index, out_position, out_group_end};
      results_seen++;
      if (due_reductions.size() == 0) begin
        $display("%0t: unexpected result word %h/%h/%0d/%b", $time,
                 out_result, out_best_index, out_position, out_group_end);
        mismatches++;
      end else begin
        want = due_reductions.pop_front();
        if (got !== want) begin
          $display("%0t: result mismatch: expected %h/%h/%0d/%b, got %h/%h/%0d/%b", $time,
                   want.result, want.best_index, want.position, want.group_end,
                   got.result, got.best_index, got.position, got.group_end);
          mismatches++;
        end
      end
    end
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_style = $urandom_range(0, 3);
        stall_left = $urandom_range(16, 300);
      end
      stall_left--;
      stall_tick++;
      case (stall_style)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 9) < 7);
        default: out_stall <= (stall_tick % 5) != 0;
      endcase
    end
  end

  // watchdog on cycles without any traffic
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no traffic for %0d cycles", $time, quiet_cycles);
      $display("strided_dim_reduction_engine test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // main sequence
  initial begin
    foreach (acc_mem[i]) begin
      acc_mem[i] = '0;
      argmax_mem[i] = '0;
    end
    row_count = 0;
    col_count = 0;
    cur_mode = MODE_SUM;
    rlen_raw = 1;
    ilen_raw = 1;

    // reset defaults: every word is its own group
    add_word_exp(32'h7FFF_FFFF, 48'h0000_7FFF_FFFF, 0, 0, 1'b1);
    add_word_exp(32'h8000_0000, 48'hFFFF_8000_0000, 0, 0, 1'b1);
    add_word_exp(32'h0000_0000, 48'h0000_0000_0000, 0, 0, 1'b1);
    add_word_exp(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 0, 0, 1'b1);
    // max with argmax over 3 rows of 2 positions, ties keep the earlier row
    add_reg(CFG_MODE, CFG_DW'(MODE_MAX));
    add_reg(CFG_REDUCE_LEN, 13'd3);
    add_reg(CFG_INNER_LEN, 13'd2);
    add_word(32'd5);
    add_word(32'hFFFF_FFFF);
    add_word(32'd5);
    add_word(32'd7);
    add_word_exp(32'd9, 48'd9, 12'd2, 10'd0, 1'b0);
    add_word_exp(32'd7, 48'd7, 12'd1, 10'd1, 1'b1);
    // zero lengths act as one
    add_reg(CFG_REDUCE_LEN, 13'd0);
    add_reg(CFG_INNER_LEN, 13'd0);
    add_word_exp(32'h8000_0000, 48'hFFFF_8000_0000, 0, 0, 1'b1);
    // sum of extremes, mode written with junk in the upper bits
    add_reg(CFG_MODE, 13'h1FFE);
    add_reg(CFG_REDUCE_LEN, 13'd2);
    add_word(32'h7FFF_FFFF);
    add_word_exp(32'h7FFF_FFFF, 48'h0000_FFFF_FFFE, 0, 0, 1'b1);
    add_word(32'h8000_0000);
    add_word_exp(32'h8000_0000, 48'hFFFF_0000_0000, 0, 0, 1'b1);
    // unused index leaves the counters alone
    add_reg(CFG_REDUCE_LEN, 13'd3);
    add_word(32'd1);
    add_reg(CFG_UNUSED, 13'h1FFF);
    add_word(32'd2);
    add_word_exp(32'd3, 48'd6, 0, 0, 1'b1);
    // a real write in mid group restarts it
    add_word(32'd10);
    add_reg(CFG_REDUCE_LEN, 13'd3);
    add_word(32'd20);
    add_word(32'd30);
    add_word_exp(32'd40, 48'd90, 0, 0, 1'b1);
    // inner length with masked upper bits, one row per group
    add_reg(CFG_REDUCE_LEN, 13'd1);
    add_reg(CFG_INNER_LEN, 13'h1803);
    add_word(32'h1234_5678);
    add_word(32'hEDCB_A987);
    add_word(32'h0001_0000);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_REG) write_reg(stim_rows[i].idx, stim_rows[i].data);
      else push_word(stim_rows[i].value, stim_rows[i].typed, stim_rows[i].res);
    end

    while (random_words < 340) run_random_phase();

    // size limits: deep and clamped reduce length, clamped and full inner length
    sweep(MODE_MAX, 13'd4096, 13'd1, 40, 1'b1);
    sweep(MODE_SUM, 13'h1FFF, 13'd1, 40, 1'b0);
    sweep(MODE_MAX, 13'd0, 13'h7FF, 40, 1'b0);
    sweep(MODE_SUM, 13'd2, 13'd1024, 40, 1'b0);

    in_valid <= 1'b0;
    while (due_reductions.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d words (%0d random, %0d in size-limit sweeps), %0d register writes",
             words_sent, random_words, sweep_words, reg_writes);
    $display("checked %0d result words, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("strided_dim_reduction_engine test passed");
    end else begin
      $display("strided_dim_reduction_engine test failed");
    end
    $finish;
  end

endmodule
